FILE: rtl/core/chti_pkg.sv
// Shared types and constants for the cuckoo hash insert core.
package chti_pkg;

  localparam int unsigned TableEntriesDef = 4096;
  localparam logic [31:0] EmptyKey        = 32'hFFFF_FFFF;
  localparam logic [31:0] FactorOneRst    = 32'd2654435761;
  localparam logic [31:0] FactorTwoRst    = 32'd2246822519;
  localparam int unsigned KickMax         = 8191;
  localparam int unsigned QueueDepth      = 4;

  localparam logic CfgIdxFactorOne = 1'b0;
  localparam logic CfgIdxFactorTwo = 1'b1;

  typedef struct packed {
    logic [31:0] payload;
    logic [31:0] key;
  } chti_item_t;

  typedef struct packed {
    logic       insert_status;
    logic [12:0] kick_count;
    logic [31:0] dropped_key;
    logic [31:0] dropped_payload;
  } chti_result_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_IDX,
    ST_ALT,
    ST_RD,
    ST_CHK,
    ST_DONE
  } chti_state_t;

  typedef enum logic [1:0] {
    PH_FIRST,
    PH_SECOND,
    PH_KICK
  } chti_phase_t;

endpackage

FILE: rtl/core/chti_front.sv
// Input side: accepts words and queues them for the insert engine.
module chti_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [31:0]          in_insert_key,
  input  logic [31:0]          in_insert_payload,
  input  logic                 hold,
  output logic                 q_valid,
  output chti_pkg::chti_item_t q_item,
  input  logic                 q_pop
);
  import chti_pkg::*;

  localparam int unsigned AW = $clog2(QueueDepth);

  chti_item_t    qmem_r [QueueDepth];
  logic [AW-1:0] wptr_r, wptr_nxt;
  logic [AW-1:0] rptr_r, rptr_nxt;
  logic [AW:0]   cnt_r, cnt_nxt;
  logic          push;
  logic          pop;

  assign in_stall = hold || (cnt_r == (AW+1)'(QueueDepth));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != '0);
  assign pop      = q_pop && q_valid;
  assign q_item   = qmem_r[rptr_r];

  always_comb begin
    wptr_nxt = push ? wptr_r + AW'(1) : wptr_r;
    rptr_nxt = pop ? rptr_r + AW'(1) : rptr_r;
    cnt_nxt  = cnt_r + (AW+1)'(push) - (AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      qmem_r[wptr_r] <= '{payload: in_insert_payload, key: in_insert_key};
    end
  end

endmodule

FILE: rtl/core/chti_back.sv
// Insert engine: hashing, bucket store and the displacement chain.
module chti_back #(
  parameter int unsigned TABLE_ENTRIES = chti_pkg::TableEntriesDef
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [31:0]            factor_one,
  input  logic [31:0]            factor_two,
  input  logic                   q_valid,
  input  chti_pkg::chti_item_t   q_item,
  output logic                   q_pop,
  output logic                   clearing,
  output logic                   res_valid,
  output chti_pkg::chti_result_t res,
  input  logic                   res_take
);
  import chti_pkg::*;

  localparam int unsigned IW = $clog2(TABLE_ENTRIES);
  localparam int unsigned KW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [63:0] WrapRem = (64'd1 << 32) % 64'(TABLE_ENTRIES);

  logic [63:0]   mem_r [TABLE_ENTRIES];
  logic [63:0]   rdata_r;

  chti_state_t   state_r, state_nxt;
  chti_phase_t   phase_r, phase_nxt;
  chti_item_t    mov_r, mov_nxt;
  logic [31:0]   p1_r, p1_nxt, p2_r, p2_nxt;
  logic [IW-1:0] a_r, a_nxt, b_r, b_nxt;
  logic [IW-1:0] h_r, h_nxt, tgt_r, tgt_nxt;
  logic [KW-1:0] kicks_r, kicks_nxt;
  logic [IW-1:0] clr_r, clr_nxt;
  logic          we;
  logic [IW-1:0] waddr;
  logic [63:0]   wdata;
  chti_result_t  pend_r, pend_nxt;
  chti_result_t  res_r, res_nxt;
  logic          res_valid_r, res_valid_nxt;
  logic [IW-1:0] alt;
  logic [IW+1:0] diff, wrapped;
  logic [63:0]   bprod1, bprod2;
  logic [12:0]   kick_sat;
  logic          rd_empty;

  assign bprod1   = {32'd0, p1_r} * 64'(TABLE_ENTRIES);
  assign bprod2   = {32'd0, p2_r} * 64'(TABLE_ENTRIES);
  assign rd_empty = (rdata_r[31:0] == EmptyKey);
  assign kick_sat = (32'(kicks_r) > 32'(KickMax)) ? 13'(KickMax) : 13'(kicks_r);

  // Alternate bucket a + b - h, folded back into the table the same way the
  // 32-bit wrap followed by a modulo would.
  always_comb begin
    diff    = (IW+2)'(a_r) + (IW+2)'(b_r) - (IW+2)'(h_r);
    wrapped = diff + (IW+2)'(WrapRem);
    if (diff[IW+1]) begin
      alt = wrapped[IW+1] ? IW'(wrapped + (IW+2)'(TABLE_ENTRIES)) : IW'(wrapped);
    end else if (diff >= (IW+2)'(TABLE_ENTRIES)) begin
      alt = IW'(diff - (IW+2)'(TABLE_ENTRIES));
    end else begin
      alt = IW'(diff);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    mov_nxt       = mov_r;
    p1_nxt        = p1_r;
    p2_nxt        = p2_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    h_nxt         = h_r;
    tgt_nxt       = tgt_r;
    kicks_nxt     = kicks_r;
    clr_nxt       = clr_r;
    we            = 1'b0;
    waddr         = tgt_r;
    wdata         = mov_r;
    q_pop         = 1'b0;
    pend_nxt      = pend_r;
    res_nxt       = res_r;
    res_valid_nxt = res_valid_r && !res_take;
    case (state_r)
      ST_CLEAR: begin
        we      = 1'b1;
        waddr   = clr_r;
        wdata   = {32'd0, EmptyKey};
        clr_nxt = clr_r + IW'(1);
        if (clr_r == IW'(TABLE_ENTRIES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          mov_nxt   = q_item;
          phase_nxt = PH_FIRST;
          kicks_nxt = '0;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        p1_nxt    = 32'(mov_r.key * factor_one);
        p2_nxt    = 32'(mov_r.key * factor_two);
        state_nxt = ST_IDX;
      end
      ST_IDX: begin
        a_nxt = IW'(bprod1 >> 32);
        b_nxt = IW'(bprod2 >> 32);
        if (phase_r == PH_FIRST) begin
          tgt_nxt   = IW'(bprod1 >> 32);
          state_nxt = ST_RD;
        end else begin
          state_nxt = ST_ALT;
        end
      end
      ST_ALT: begin
        tgt_nxt   = alt;
        state_nxt = ST_RD;
      end
      ST_RD: begin
        state_nxt = ST_CHK;
      end
      ST_CHK: begin
        if (phase_r == PH_FIRST && !rd_empty) begin
          tgt_nxt   = b_r;
          phase_nxt = PH_SECOND;
          state_nxt = ST_RD;
        end else begin
          we = 1'b1;
          if (rd_empty) begin
            pend_nxt  = '{insert_status: 1'b0, kick_count: kick_sat,
                          dropped_key: EmptyKey, dropped_payload: 32'd0};
            state_nxt = ST_DONE;
          end else if (kicks_r == KW'(TABLE_ENTRIES - 1)) begin
            kicks_nxt = kicks_r + KW'(1);
            pend_nxt  = '{insert_status: 1'b1,
                          kick_count: (TABLE_ENTRIES > KickMax) ? 13'(KickMax)
                                                                : 13'(TABLE_ENTRIES),
                          dropped_key: rdata_r[31:0], dropped_payload: rdata_r[63:32]};
            state_nxt = ST_DONE;
          end else begin
            kicks_nxt = kicks_r + KW'(1);
            mov_nxt   = rdata_r;
            h_nxt     = tgt_r;
            phase_nxt = PH_KICK;
            state_nxt = ST_MUL;
          end
        end
      end
      ST_DONE: begin
        if (!res_valid_r || res_take) begin
          res_nxt       = pend_r;
          res_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      phase_r     <= PH_FIRST;
      clr_r       <= '0;
      kicks_r     <= '0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      clr_r       <= clr_nxt;
      kicks_r     <= kicks_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mov_r  <= mov_nxt;
    p1_r   <= p1_nxt;
    p2_r   <= p2_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    h_r    <= h_nxt;
    tgt_r  <= tgt_nxt;
    pend_r <= pend_nxt;
    res_r  <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[tgt_r];
  end

  assign clearing  = (state_r == ST_CLEAR);
  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

FILE: rtl/core/cuckoo_hash_table_insert_core.sv
// Top level of the two-choice cuckoo hash insert core.
//
//   channel   direction  handshake          payload
//   in_       input      in_valid/in_stall  in_insert_key, in_insert_payload
//   out_      output     out_valid/out_stall out_insert_status, out_kick_count,
//                                            out_dropped_key, out_dropped_payload
//   cfg_      input      cfg_we             cfg_index, cfg_data
//
// An insert that lands in its first bucket hashes (multiply, then scale), reads
// and checks it; one that lands in its second also reads and checks that one;
// each displacement adds a hash, the alternate bucket, a read and a check, a
// loop set by the bucket store and the two-step hash. After reset the store is
// swept to empty, one entry per cycle, while in_stall stays high. A four-word
// queue lets words arrive while an insert runs, and a full result register lets
// the engine start the next word while out_stall holds the last one.
module cuckoo_hash_table_insert_core #(
  parameter int unsigned TABLE_ENTRIES = chti_pkg::TableEntriesDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_insert_key,
  input  logic [31:0] in_insert_payload,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_insert_status,
  output logic [12:0] out_kick_count,
  output logic [31:0] out_dropped_key,
  output logic [31:0] out_dropped_payload,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);
  import chti_pkg::*;

  logic [31:0]  factor_one_r;
  logic [31:0]  factor_two_r;
  logic         q_valid;
  logic         q_pop;
  chti_item_t   q_item;
  logic         clearing;
  chti_result_t res;

  // The hash factors are to be rewritten only while the core is idle; the core itself does not enforce this.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      factor_one_r <= FactorOneRst;
      factor_two_r <= FactorTwoRst;
    end else if (cfg_we) begin
      if (cfg_index == CfgIdxFactorOne) begin
        factor_one_r <= cfg_data;
      end else begin
        factor_two_r <= cfg_data;
      end
    end
  end

  chti_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_insert_key     (in_insert_key),
    .in_insert_payload (in_insert_payload),
    .hold              (clearing),
    .q_valid           (q_valid),
    .q_item            (q_item),
    .q_pop             (q_pop)
  );

  chti_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .factor_one (factor_one_r),
    .factor_two (factor_two_r),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .clearing   (clearing),
    .res_valid  (out_valid),
    .res        (res),
    .res_take   (!out_stall)
  );

  assign out_insert_status   = res.insert_status;
  assign out_kick_count      = res.kick_count;
  assign out_dropped_key     = res.dropped_key;
  assign out_dropped_payload = res.dropped_payload;

endmodule
